// ===== design/grm_pkg.sv =====
// Shared types and constants for the grid ray march unit.
// Item and result word layouts, status and kind codes, sequencer states.
// No dependencies.
package grm_pkg;

	localparam int MAP_WIDTH_DEF  = 64;
	localparam int MAP_HEIGHT_DEF = 64;

	localparam int CELL_W   = 2;
	localparam int COORD_W  = 6;
	localparam int DIST_W   = 32;
	localparam int STEPS_W  = 12;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [STEPS_W-1:0] MAX_STEPS_RESET = 12'd256;

	localparam logic REG_MAX_STEPS = 1'b0;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

	localparam logic [CELL_W-1:0] KIND_EMPTY = 2'd0;

	localparam logic [1:0] STATUS_WRITTEN = 2'd0;
	localparam logic [1:0] STATUS_HIT     = 2'd1;
	localparam logic [1:0] STATUS_LIMIT   = 2'd2;
	localparam logic [1:0] STATUS_LEFT    = 2'd3;

	typedef struct packed {
		logic                command;
		logic [COORD_W-1:0]  cell_x;
		logic [COORD_W-1:0]  cell_y;
		logic [CELL_W-1:0]   cell_kind;
		logic [DIST_W-1:0]   side_dist_x;
		logic [DIST_W-1:0]   side_dist_y;
		logic [DIST_W-1:0]   delta_x;
		logic [DIST_W-1:0]   delta_y;
		logic                step_x_neg;
		logic                step_y_neg;
	} grm_item_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [CELL_W-1:0]   hit_kind;
		logic                hit_side;
		logic [COORD_W-1:0]  hit_x;
		logic [COORD_W-1:0]  hit_y;
		logic [DIST_W-1:0]   final_dist_x;
		logic [DIST_W-1:0]   final_dist_y;
		logic [STEPS_W-1:0]  steps_taken;
	} grm_result_t;

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_MARCH
	} grm_state_t;

endpackage

// ===== design/grid_ray_march_unit.sv =====
// Grid ray march unit: cell map memory, ray stepping sequencer, APB register.
// Depends on grm_pkg.
//
// After reset the unit sweeps the cell map to empty, one cell per cycle, with busy high
// until all MAP_WIDTH*MAP_HEIGHT cells (4096 with the defaults) are cleared. The result of
// a cell write word appears in the cycle after it is taken. A cast word enters the march
// state, where the map memory is read once for each step that stays on the map, and the
// step decision is made while the previous cell's read data returns. A ray starting off
// the map reports in the cycle after it is taken. Each result is shown with done high for
// exactly one cycle and cannot be stalled; start is taken only while busy is low.
module grid_ray_march_unit
	import grm_pkg::*;
#(
	parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
	parameter int MAP_HEIGHT = MAP_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  grm_item_t          item,
	output logic               done,
	output grm_result_t        result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(MAP_WIDTH);
	localparam int YW    = $clog2(MAP_HEIGHT);

	logic [CELL_W-1:0] map_mem [DEPTH];

	grm_state_t         state_q, state_d;
	logic [AW-1:0]      clr_addr_q;
	logic [STEPS_W-1:0] max_steps_q;
	logic               pend_q;
	logic               done_q;
	grm_result_t        result_q;
	logic [CELL_W-1:0]  rd_data_q;

	logic [XW-1:0]      x_q;
	logic [YW-1:0]      y_q;
	logic [AW-1:0]      addr_q;
	logic [DIST_W-1:0]  sdx_q, sdy_q, dx_q, dy_q;
	logic               sxn_q, syn_q, side_q;
	logic [STEPS_W-1:0] steps_q;

	logic               accept, start_in_map, reg_sel, reg_wr;
	logic [AW-1:0]      start_addr, next_addr;
	logic               go_x, leave, hit, at_limit, step_take, finish;
	logic [DIST_W:0]    sum_x, sum_y;
	logic [DIST_W-1:0]  sat_x, sat_y, new_sdx, new_sdy;
	logic [XW-1:0]      next_x;
	logic [YW-1:0]      next_y;
	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [CELL_W-1:0]  mem_wdata;
	logic               done_d;
	grm_result_t        result_d;

	assign busy   = (state_q != FSM_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;
	assign pready = 1'b1;

	assign reg_sel = (paddr[PADDR_W-1:2] == REG_MAX_STEPS);
	assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? PDATA_W'(max_steps_q) : '0;

	assign start_in_map = (32'(item.cell_x) < 32'(MAP_WIDTH))
		&& (32'(item.cell_y) < 32'(MAP_HEIGHT));
	assign start_addr = AW'(32'(item.cell_x) * 32'(MAP_HEIGHT) + 32'(item.cell_y));

	// step datapath
	assign go_x  = (sdx_q < sdy_q);
	assign sum_x = {1'b0, sdx_q} + {1'b0, dx_q};
	assign sum_y = {1'b0, sdy_q} + {1'b0, dy_q};
	assign sat_x = sum_x[DIST_W] ? '1 : sum_x[DIST_W-1:0];
	assign sat_y = sum_y[DIST_W] ? '1 : sum_y[DIST_W-1:0];
	assign new_sdx = go_x ? sat_x : sdx_q;
	assign new_sdy = go_x ? sdy_q : sat_y;
	assign next_x  = sxn_q ? x_q - XW'(1) : x_q + XW'(1);
	assign next_y  = syn_q ? y_q - YW'(1) : y_q + YW'(1);

	always_comb begin
		if (go_x) begin
			leave     = sxn_q ? (x_q == '0) : (x_q == XW'(MAP_WIDTH - 1));
			next_addr = sxn_q ? addr_q - AW'(MAP_HEIGHT) : addr_q + AW'(MAP_HEIGHT);
		end else begin
			leave     = syn_q ? (y_q == '0) : (y_q == YW'(MAP_HEIGHT - 1));
			next_addr = syn_q ? addr_q - AW'(1) : addr_q + AW'(1);
		end
	end

	assign hit       = pend_q && (rd_data_q != KIND_EMPTY);
	assign at_limit  = (steps_q == max_steps_q);
	assign step_take = !hit && !at_limit;
	assign finish    = hit || at_limit || leave;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_CLEAR: begin
				if (clr_addr_q == AW'(DEPTH - 1)) state_d = FSM_IDLE;
			end
			FSM_IDLE: begin
				if (accept && item.command == CMD_CAST && start_in_map) state_d = FSM_MARCH;
			end
			FSM_MARCH: begin
				if (finish) state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = start_addr;
		mem_wdata = item.cell_kind;
		mem_re    = 1'b0;
		mem_raddr = next_addr;
		done_d    = 1'b0;
		result_d  = '0;
		unique case (state_q)
			FSM_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = KIND_EMPTY;
			end
			FSM_IDLE: begin
				if (accept) begin
					if (item.command == CMD_WRITE) begin
						mem_we          = start_in_map;
						done_d          = 1'b1;
						result_d.status = STATUS_WRITTEN;
					end else if (!start_in_map) begin
						done_d                = 1'b1;
						result_d.status       = STATUS_LEFT;
						result_d.hit_x        = item.cell_x;
						result_d.hit_y        = item.cell_y;
						result_d.final_dist_x = item.side_dist_x;
						result_d.final_dist_y = item.side_dist_y;
					end
				end
			end
			FSM_MARCH: begin
				mem_re                = step_take && !leave;
				done_d                = finish;
				result_d.hit_x        = COORD_W'(32'(x_q));
				result_d.hit_y        = COORD_W'(32'(y_q));
				result_d.hit_side     = step_take ? !go_x : side_q;
				result_d.final_dist_x = step_take ? new_sdx : sdx_q;
				result_d.final_dist_y = step_take ? new_sdy : sdy_q;
				result_d.steps_taken  = step_take ? steps_q + STEPS_W'(1) : steps_q;
				priority if (hit) begin
					result_d.status   = STATUS_HIT;
					result_d.hit_kind = rd_data_q;
				end else if (at_limit) begin
					result_d.status = STATUS_LIMIT;
				end else begin
					result_d.status = STATUS_LEFT;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_CLEAR;
			clr_addr_q  <= '0;
			max_steps_q <= MAX_STEPS_RESET;
			pend_q      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= mem_re;
			done_q  <= done_d;
			if (state_q == FSM_CLEAR) clr_addr_q <= clr_addr_q + AW'(1);
			if (reg_wr) max_steps_q <= pwdata[STEPS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (done_d) result_q <= result_d;
		if (state_q == FSM_IDLE && accept) begin
			x_q     <= XW'(item.cell_x);
			y_q     <= YW'(item.cell_y);
			addr_q  <= start_addr;
			sdx_q   <= item.side_dist_x;
			sdy_q   <= item.side_dist_y;
			dx_q    <= item.delta_x;
			dy_q    <= item.delta_y;
			sxn_q   <= item.step_x_neg;
			syn_q   <= item.step_y_neg;
			side_q  <= 1'b0;
			steps_q <= '0;
		end else if (state_q == FSM_MARCH && step_take) begin
			sdx_q   <= new_sdx;
			sdy_q   <= new_sdy;
			side_q  <= !go_x;
			steps_q <= steps_q + STEPS_W'(1);
			if (!leave) begin
				addr_q <= next_addr;
				if (go_x) x_q <= next_x;
				else      y_q <= next_y;
			end
		end
	end

	// cell map: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) map_mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_data_q <= map_mem[mem_raddr];
	end

endmodule

// ===== tb/tb_grid_ray_march_unit.sv =====
// Self-checking testbench for grid_ray_march_unit: map writes, ray casts, step limit register.
// Predicts each result word in step with the accepted words and checks every result field.
// Depends on grm_pkg and grid_ray_march_unit.
module tb_grid_ray_march_unit;
	import grm_pkg::*;

	localparam logic [CELL_W-1:0] KIND_WALL      = 2'd1;
	localparam logic [CELL_W-1:0] KIND_DOOR      = 2'd2;
	localparam logic [CELL_W-1:0] KIND_OPEN_DOOR = 2'd3;

	localparam logic [PADDR_W-1:0] ADDR_MAX_STEPS = PADDR_W'(4 * REG_MAX_STEPS);

	localparam logic [DIST_W-1:0] ONE  = 32'h0001_0000;
	localparam logic [DIST_W-1:0] QMAX = 32'hFFFF_FFFF;

	localparam int GRID_W = MAP_WIDTH_DEF;
	localparam int GRID_H = MAP_HEIGHT_DEF;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	grm_item_t          word_in = '0;
	logic               done;
	grm_result_t        result;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	logic [CELL_W-1:0]  grid_cells [GRID_W][GRID_H];
	logic [STEPS_W-1:0] step_cap = MAX_STEPS_RESET;
	grm_result_t        pending_results [$];
	int                 fault_count = 0;
	bit                 no_gaps = 1'b0;

	grid_ray_march_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(word_in),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	initial begin
		#8_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic log_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endtask

	// predicted result of one accepted word; writes update the local map copy
	function automatic grm_result_t march_ray(input grm_item_t w);
		grm_result_t r;
		int x, y, nx, ny, sx, sy;
		logic [DIST_W-1:0] sdx, sdy;
		logic [DIST_W:0] sum;
		int n;
		bit stop;
		r = '0;
		if (w.command == CMD_WRITE) begin
			grid_cells[w.cell_x][w.cell_y] = w.cell_kind;
			r.status = STATUS_WRITTEN;
			return r;
		end
		x = w.cell_x;
		y = w.cell_y;
		sx = w.step_x_neg ? -1 : 1;
		sy = w.step_y_neg ? -1 : 1;
		sdx = w.side_dist_x;
		sdy = w.side_dist_y;
		n = 0;
		stop = 1'b0;
		r.status = STATUS_LIMIT;
		while (!stop && n < int'(step_cap)) begin
			nx = x;
			ny = y;
			if (sdx < sdy) begin
				r.hit_side = 1'b0;
				sum = {1'b0, sdx} + {1'b0, w.delta_x};
				sdx = sum[DIST_W] ? QMAX : sum[DIST_W-1:0];
				nx = x + sx;
			end else begin
				r.hit_side = 1'b1;
				sum = {1'b0, sdy} + {1'b0, w.delta_y};
				sdy = sum[DIST_W] ? QMAX : sum[DIST_W-1:0];
				ny = y + sy;
			end
			n++;
			if (nx < 0 || nx >= GRID_W || ny < 0 || ny >= GRID_H) begin
				r.status = STATUS_LEFT;
				stop = 1'b1;
			end else begin
				x = nx;
				y = ny;
				if (grid_cells[x][y] != KIND_EMPTY) begin
					r.status = STATUS_HIT;
					r.hit_kind = grid_cells[x][y];
					stop = 1'b1;
				end
			end
		end
		r.hit_x = x[COORD_W-1:0];
		r.hit_y = y[COORD_W-1:0];
		r.final_dist_x = sdx;
		r.final_dist_y = sdy;
		r.steps_taken = n[STEPS_W-1:0];
		return r;
	endfunction

	function automatic grm_item_t make_write(input int x, input int y,
			input logic [CELL_W-1:0] kind);
		grm_item_t w;
		w.side_dist_x = $urandom;
		w.side_dist_y = $urandom;
		w.delta_x = $urandom;
		w.delta_y = $urandom;
		w.step_x_neg = 1'($urandom_range(1));
		w.step_y_neg = 1'($urandom_range(1));
		w.command = CMD_WRITE;
		w.cell_x = x[COORD_W-1:0];
		w.cell_y = y[COORD_W-1:0];
		w.cell_kind = kind;
		return w;
	endfunction

	function automatic grm_item_t make_cast(input int x, input int y,
			input logic [DIST_W-1:0] sdx, input logic [DIST_W-1:0] sdy,
			input logic [DIST_W-1:0] dx, input logic [DIST_W-1:0] dy,
			input logic xneg, input logic yneg);
		grm_item_t w;
		w.command = CMD_CAST;
		w.cell_x = x[COORD_W-1:0];
		w.cell_y = y[COORD_W-1:0];
		w.cell_kind = CELL_W'($urandom_range(3));
		w.side_dist_x = sdx;
		w.side_dist_y = sdy;
		w.delta_x = dx;
		w.delta_y = dy;
		w.step_x_neg = xneg;
		w.step_y_neg = yneg;
		return w;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (no_gaps)
			return 0;
		roll = $urandom_range(99);
		if (roll < 45)
			return 0;
		if (roll < 80)
			return $urandom_range(3, 1);
		if (roll < 96)
			return $urandom_range(15, 4);
		return $urandom_range(60, 20);
	endfunction

	// called at a rising edge; start is left high when the next word follows at once
	task automatic send_word(input grm_item_t w);
		int gap;
		start <= 1'b1;
		word_in <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(march_ray(w));
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_words();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic program_step_cap(input logic [STEPS_W-1:0] cap);
		drain_words();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_MAX_STEPS;
		pwdata <= {{(PDATA_W-STEPS_W){1'b0}}, cap};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		step_cap = cap;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[STEPS_W-1:0] !== cap)
			log_fault($sformatf("max_steps readback: exp %0d got %0d", cap, prdata));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin : result_check
		grm_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				log_fault($sformatf("result word with none pending: status %0d",
					result.status));
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status || result.hit_kind !== want.hit_kind ||
						result.hit_side !== want.hit_side || result.hit_x !== want.hit_x ||
						result.hit_y !== want.hit_y ||
						result.final_dist_x !== want.final_dist_x ||
						result.final_dist_y !== want.final_dist_y ||
						result.steps_taken !== want.steps_taken)
					log_fault($sformatf({"mismatch exp st%0d k%0d s%0d (%0d,%0d) %h %h n%0d\n",
						"         got st%0d k%0d s%0d (%0d,%0d) %h %h n%0d"},
						want.status, want.hit_kind, want.hit_side, want.hit_x, want.hit_y,
						want.final_dist_x, want.final_dist_y, want.steps_taken,
						result.status, result.hit_kind, result.hit_side, result.hit_x,
						result.hit_y, result.final_dist_x, result.final_dist_y,
						result.steps_taken));
			end
		end
	end

	task automatic test_writes_and_hits();
		send_word(make_cast(10, 10, ONE, ONE, ONE, ONE, 1'b0, 1'b0));
		send_word(make_write(12, 10, KIND_WALL));
		send_word(make_cast(10, 10, 32'd0, QMAX, ONE, ONE, 1'b0, 1'b0));
		send_word(make_write(10, 7, KIND_DOOR));
		send_word(make_cast(10, 10, QMAX, 32'd0, ONE, ONE, 1'b0, 1'b1));
		send_word(make_write(8, 10, KIND_OPEN_DOOR));
		send_word(make_cast(10, 10, 32'd0, QMAX, ONE, ONE, 1'b1, 1'b0));
		// wall cleared again, ray runs on to the map edge
		send_word(make_write(12, 10, KIND_EMPTY));
		send_word(make_cast(10, 10, 32'd0, QMAX, ONE, ONE, 1'b0, 1'b0));
		// start cell holding a wall is not looked at
		send_word(make_write(30, 30, KIND_WALL));
		send_word(make_cast(30, 30, QMAX, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1));
		// side distance saturation
		send_word(make_cast(20, 20, QMAX, 32'hFFFF_FF00, QMAX, 32'h0000_0200, 1'b0, 1'b0));
		send_word(make_cast(63, 63, 32'd0, 32'd1, ONE, ONE, 1'b0, 1'b0));
		send_word(make_cast(0, 0, QMAX, QMAX, QMAX, QMAX, 1'b1, 1'b1));
		send_word(make_cast(0, 63, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0));
	endtask

	task automatic test_step_limit();
		program_step_cap(12'd1);
		send_word(make_cast(40, 40, 32'd0, ONE, ONE, ONE, 1'b0, 1'b0));
		send_word(make_write(41, 40, KIND_WALL));
		send_word(make_cast(40, 40, 32'd0, ONE, ONE, ONE, 1'b0, 1'b0));
		program_step_cap(12'd0);
		send_word(make_cast(40, 40, 32'h1234_5678, ONE, ONE, ONE, 1'b1, 1'b1));
		program_step_cap(12'd4095);
		send_word(make_cast(40, 40, ONE, 32'd0, ONE, ONE, 1'b0, 1'b0));
		send_word(make_cast(5, 50, 32'd3, 32'd7, 32'd5, 32'd3, 1'b1, 1'b0));
		program_step_cap(12'd3);
		send_word(make_cast(45, 45, ONE, ONE, ONE, ONE, 1'b0, 1'b0));
	endtask

	function automatic logic [DIST_W-1:0] pick_dist(input int mode, input bit is_delta);
		case (mode)
			0: return is_delta ? $urandom_range(8 * ONE) : $urandom_range(2 * ONE);
			1: return $urandom;
			default: begin
				case ($urandom_range(4))
					0: return 32'd0;
					1: return QMAX;
					2: return ONE;
					3: return 32'hFFFF_0000;
					default: return 32'h8000_0000;
				endcase
			end
		endcase
	endfunction

	function automatic int pick_coord();
		return ($urandom_range(99) < 60) ? $urandom_range(47, 16) : $urandom_range(63);
	endfunction

	task automatic test_random_marching();
		int roll, mode, kind_roll;
		logic [CELL_W-1:0] kind;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: program_step_cap(12'd256);
				1: program_step_cap(STEPS_W'($urandom_range(20, 1)));
				4: program_step_cap(12'd4095);
				default: program_step_cap(STEPS_W'($urandom_range(4095, 1)));
			endcase
			for (int i = 0; i < 160; i++) begin
				no_gaps = (i >= 60 && i < 90);
				roll = $urandom_range(99);
				if (roll < 30) begin
					kind_roll = $urandom_range(99);
					kind = (kind_roll < 50) ? KIND_WALL : (kind_roll < 65) ? KIND_DOOR :
						(kind_roll < 80) ? KIND_OPEN_DOOR : KIND_EMPTY;
					send_word(make_write(pick_coord(), pick_coord(), kind));
				end else begin
					mode = $urandom_range(99);
					mode = (mode < 60) ? 0 : (mode < 85) ? 1 : 2;
					send_word(make_cast(pick_coord(), pick_coord(),
						pick_dist(mode, 1'b0), pick_dist(mode, 1'b0),
						pick_dist(mode, 1'b1), pick_dist(mode, 1'b1),
						1'($urandom_range(1)), 1'($urandom_range(1))));
				end
			end
			no_gaps = 1'b0;
		end
	endtask

	initial begin
		for (int x = 0; x < GRID_W; x++)
			for (int y = 0; y < GRID_H; y++)
				grid_cells[x][y] = KIND_EMPTY;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		while (busy)
			@(posedge clk);
		test_writes_and_hits();
		test_step_limit();
		test_random_marching();
		drain_words();
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0)
			log_fault($sformatf("%0d result words never arrived", pending_results.size()));
		if (fault_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
design/grm_pkg.sv
design/grid_ray_march_unit.sv
tb/tb_grid_ray_march_unit.sv
